@@ src/cag_pkg.sv @@
// Package for the cosine antenna gain block: constants, register codes and the attenuation ROM.
package cag_pkg;

	// Angle and table geometry
	localparam int ANGLE_BITS      = 16;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int ROM_DEPTH       = 1 << TABLE_ADDR_BITS;
	localparam int K_W             = TABLE_ADDR_BITS + 1;

	// Field widths
	localparam int AZ_W   = 16;
	localparam int EXP_W  = 20;
	localparam int GAIN_W = 16;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 2;

	// Attenuation entry width (unsigned Q16 dB, bounded near 181 dB)
	localparam int ATT_W  = 24;
	localparam int PROD_W = ATT_W + EXP_W;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_ORIENTATION = 2'd0;
	localparam logic [IDX_W-1:0] REG_EXPONENT    = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_GAIN    = 2'd2;

	localparam logic [EXP_W-1:0] EXPONENT_RESET = 20'd2550;

	// Table build constants
	localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
	localparam logic [63:0] DB_PER_OCTAVE_Q24 = 64'd101008905;
	localparam logic [63:0] ONE_Q30           = 64'd1 << 30;

	typedef logic [63:0] div_tab_t [8];
	localparam div_tab_t DIV_COS = '{64'd1, 64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
		64'd182};
	localparam div_tab_t DIV_SIN = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210};

	typedef logic [ATT_W-1:0] atten_rom_t [ROM_DEPTH];

	// Unsigned long division by shift and subtract, used while the table is built
	function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// One entry: -20*log10(cos(theta)) in Q16, theta = k*(pi/2)/2^TABLE_ADDR_BITS
	function automatic logic [ATT_W-1:0] atten_entry(int unsigned k);
		logic [63:0]        n;
		logic [63:0]        m;
		logic [63:0]        z;
		logic [63:0]        z2;
		logic [63:0]        term;
		logic [63:0]        x;
		logic [63:0]        frac;
		logic [63:0]        neg_l2;
		logic [63:0]        p;
		logic [63:0]        dv;
		logic signed [63:0] sum;
		logic               use_sin;
		int                 e;
		n       = 64'd1 << TABLE_ADDR_BITS;
		use_sin = 64'(k) > (n >> 1);
		m       = use_sin ? (n - 64'(k)) : 64'(k);
		z       = (m * HALF_PI_Q30) >> TABLE_ADDR_BITS;
		z2      = (z * z) >> 30;
		term    = use_sin ? z : ONE_Q30;
		sum     = signed'(term);
		// Taylor series, eight terms
		for (int i = 1; i <= 7; i++) begin
			dv   = use_sin ? DIV_SIN[i] : DIV_COS[i];
			term = udiv64((term * z2) >> 30, dv);
			if ((i & 1) == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 64'sd1) begin
			sum = 64'sd1;
		end
		if (sum > signed'(ONE_Q30)) begin
			sum = signed'(ONE_Q30);
		end
		x = unsigned'(sum);
		// Normalize to [1,2) in Q30
		e = 30;
		for (int j = 0; j < 30; j++) begin
			if (e > 0 && x < (64'd1 << e)) begin
				e = e - 1;
			end
		end
		x    = x << (30 - e);
		frac = '0;
		// Fractional log2 by repeated squaring
		for (int j = 0; j < 24; j++) begin
			x    = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x    = x >> 1;
				frac = frac | 64'd1;
			end
		end
		neg_l2 = (64'(30 - e) << 24) - frac;
		p      = neg_l2 * DB_PER_OCTAVE_Q24;
		return ATT_W'((p + (64'd1 << 31)) >> 32);
	endfunction

	function automatic atten_rom_t build_rom();
		atten_rom_t r;
		for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
			r[k] = atten_entry(k);
		end
		return r;
	endfunction

	localparam atten_rom_t ATTEN_ROM = build_rom();

endpackage

@@ src/cosine_antenna_gain.sv @@
// Cosine antenna gain pattern: four-stage pipeline from azimuth to saturated gain in dB.
//
//  channel   | signals                                   | dir | transaction
//  azimuth   | azimuth_valid, azimuth_stall, azimuth     | in  | valid && !stall
//  gain      | gain_valid, gain_stall, gain_db, saturated| out | valid && !stall
//  config    | cfg_we, cfg_index, cfg_wdata              | in  | cfg_we
//
// One transaction enters per cycle when the output is not stalled.
// Stages: angle wrap and fold, ROM read, exponent multiply, round/subtract/saturate.
// Each stage advances when it is empty or the stage after it advances, so bubbles close.
// Reset clears the valid bits and loads the register reset values; the ROM is constant.
module cosine_antenna_gain import cag_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     azimuth_valid,
	output logic                     azimuth_stall,
	input  logic signed [AZ_W-1:0]   azimuth,
	output logic                     gain_valid,
	input  logic                     gain_stall,
	output logic signed [GAIN_W-1:0] gain_db,
	output logic                     saturated,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_wdata
);

	localparam int HALF_W = ANGLE_BITS + TABLE_ADDR_BITS + 1;
	localparam int SHR    = (ANGLE_BITS - 1 >= TABLE_ADDR_BITS) ?
		(ANGLE_BITS - 1 - TABLE_ADDR_BITS) : 0;
	localparam int SHL    = (ANGLE_BITS - 1 >= TABLE_ADDR_BITS) ?
		0 : (TABLE_ADDR_BITS + 1 - ANGLE_BITS);
	localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam int ATT_R_W = PROD_W - 15;
	localparam int SUM_W   = ATT_R_W + 2;

	// Configuration registers
	logic signed [AZ_W-1:0]   orientation_q;
	logic [EXP_W-1:0]         exponent_q;
	logic signed [GAIN_W-1:0] max_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q <= '0;
			exponent_q    <= EXPONENT_RESET;
			max_gain_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIENTATION: orientation_q <= AZ_W'(cfg_wdata);
				REG_EXPONENT:    exponent_q    <= cfg_wdata;
				REG_MAX_GAIN:    max_gain_q    <= GAIN_W'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Stage control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !gain_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign azimuth_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= azimuth_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: wrap the difference, fold to |phi|, form the table address
	logic signed [31:0]      diff;
	logic [ANGLE_BITS-1:0]   d;
	logic [ANGLE_BITS-1:0]   mag;
	logic [HALF_W-1:0]       mag_wide;
	logic [K_W-1:0]          k_next;

	always_comb begin
		diff     = 32'(azimuth) - 32'(orientation_q);
		d        = diff[ANGLE_BITS-1:0];
		mag      = (d <= HALF_TURN) ? d : (ANGLE_BITS'(0) - d);
		mag_wide = (HALF_W'(mag) << SHL) >> SHR;
		k_next   = mag_wide[K_W-1:0];
	end

	logic [K_W-1:0] k_s1;
	logic           ez_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			k_s1  <= k_next;
			ez_s1 <= (exponent_q == '0);
		end
	end

	// Stage 2: registered ROM read; the pole address is flagged, not stored
	logic [ATT_W-1:0] rom_s2;
	logic             pole_s2;
	logic             ez_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			rom_s2  <= ATTEN_ROM[k_s1[TABLE_ADDR_BITS-1:0]];
			pole_s2 <= k_s1[TABLE_ADDR_BITS];
			ez_s2   <= ez_s1;
		end
	end

	// Stage 3: scale by the exponent
	logic [PROD_W-1:0] prod_s3;
	logic              pole_s3;
	logic              ez_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3 <= PROD_W'(rom_s2) * PROD_W'(exponent_q);
			pole_s3 <= pole_s2;
			ez_s3   <= ez_s2;
		end
	end

	// Stage 4: round to Q8.8, subtract from max gain, saturate
	logic [PROD_W:0]          prod_rnd;
	logic [ATT_R_W-1:0]       att;
	logic signed [SUM_W-1:0]  gain_full;
	logic signed [GAIN_W-1:0] gain_next;
	logic                     sat_next;

	always_comb begin
		prod_rnd  = (PROD_W + 1)'(prod_s3) + ((PROD_W + 1)'(1) << 15);
		att       = prod_rnd[PROD_W:16];
		gain_full = SUM_W'(max_gain_q) - signed'(SUM_W'(att));
		gain_next = GAIN_W'(gain_full);
		sat_next  = 1'b0;
		if (ez_s3) begin
			gain_next = max_gain_q;
		end else if (pole_s3) begin
			gain_next = {1'b1, {(GAIN_W-1){1'b0}}};
			sat_next  = 1'b1;
		end else if (gain_full > SUM_W'(32767)) begin
			gain_next = {1'b0, {(GAIN_W-1){1'b1}}};
			sat_next  = 1'b1;
		end else if (gain_full < -SUM_W'(32768)) begin
			gain_next = {1'b1, {(GAIN_W-1){1'b0}}};
			sat_next  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			gain_db   <= gain_next;
			saturated <= sat_next;
		end
	end

	assign gain_valid = v_s4;

`ifndef SYNTH
	// A held multiply stage keeps its product
	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en3 |=> v_s3 && $stable(prod_s3))
		else $error("multiply stage changed while held");

	// Pole with nonzero exponent floors the gain
	a_pole_floor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 && pole_s3 && !ez_s3 |=> gain_valid && saturated &&
		gain_db == {1'b1, {(GAIN_W-1){1'b0}}})
		else $error("pole did not floor the gain");

	// A clipped result sits at a field limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		gain_valid && saturated |-> gain_db == {1'b1, {(GAIN_W-1){1'b0}}} ||
		gain_db == {1'b0, {(GAIN_W-1){1'b1}}})
		else $error("saturated flag set away from a limit");

	// Input is only stalled when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		azimuth_stall |-> v_s1 && v_s2 && v_s3 && v_s4)
		else $error("input stalled with room in the pipeline");
`endif

endmodule
